// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ray/sphere hit distance core.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active-low reset).
`define RSH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define RSH_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    `RSH_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/rsh_pkg.sv =====
// Package for the ray/sphere hit distance core: field widths, constants and
// the item structs passed between stages. No dependencies.
`timescale 1ns / 1ps

package rsh_pkg;

    localparam int POS_W     = 24;  // Q7.16 position
    localparam int DIR_W     = 18;  // Q1.16 direction
    localparam int RADIUS_W  = 23;  // unsigned Q7.16 radius
    localparam int FRAC_W    = 16;
    localparam int W_W       = 25;  // o - c, Q8.16
    localparam int BPROD_W   = 43;  // d * w
    localparam int BSUM_W    = 45;  // b, 32 fraction bits
    localparam int SQ_W      = 48;  // w * w, non-negative
    localparam int LSUM_W    = 50;  // |w|^2
    localparam int RSQ_W     = 46;  // r^2
    localparam int B16_W     = 29;  // b rounded to 16 fraction bits
    localparam int CC_W      = 51;  // |w|^2 - r^2, signed
    localparam int DELTA_W   = 56;  // discriminant magnitude, even for digit pairs
    localparam int ROOT_W    = DELTA_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int DIST_W    = 32;
    localparam int ROUND_HALF = 32768;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6554;  // 0.1

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [POS_W-1:0] origin_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
    } ray_item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [B16_W-1:0] b16;
        logic [DELTA_W-1:0]      delta;
    } sqrt_item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [B16_W-1:0] b16;
        logic [ROOT_W-1:0]       root;
    } root_item_t;

endpackage

// ===== rtl/core/rsh_cfg.sv =====
// Radius configuration register and its registered square.
// Depends on rsh_pkg.
`timescale 1ns / 1ps

module rsh_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [rsh_pkg::RADIUS_W-1:0]  cfg_data,
    output logic [rsh_pkg::RSQ_W-1:0]     rsq
);

    localparam int RSQW = rsh_pkg::RSQ_W;

    logic [rsh_pkg::RADIUS_W-1:0] radius_reg;
    logic [RSQW-1:0]              rsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= rsh_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    // Registered square of the radius register, settled long before any item reaches its use.
    always_ff @(posedge aclk) begin
        rsq_reg <= RSQW'(radius_reg) * RSQW'(radius_reg);
    end

    assign rsq = rsq_reg;

endmodule

// ===== rtl/core/rsh_front.sv =====
// Six-stage front end: difference vector, products, sums, rounding of b,
// b squared and the discriminant. Depends on rsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsh_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rsh_pkg::ray_item_t         in_item,
    input  logic [rsh_pkg::RSQ_W-1:0]  rsq,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rsh_pkg::sqrt_item_t        out_item
);

    localparam int NSTG  = 6;
    localparam int WW    = rsh_pkg::W_W;
    localparam int BPW   = rsh_pkg::BPROD_W;
    localparam int BSW   = rsh_pkg::BSUM_W;
    localparam int SQW   = rsh_pkg::SQ_W;
    localparam int LSW   = rsh_pkg::LSUM_W;
    localparam int B16W  = rsh_pkg::B16_W;
    localparam int CCW   = rsh_pkg::CC_W;
    localparam int DW    = rsh_pkg::DELTA_W;
    localparam int FW    = rsh_pkg::FRAC_W;
    localparam int DIRW  = rsh_pkg::DIR_W;
    localparam int BB_W  = 2 * B16W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;

    assign en[NSTG] = out_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: w = o - c
    logic signed [WW-1:0]   w_reg [3];
    logic signed [DIRW-1:0] d_reg [3];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            w_reg[0] <= WW'(in_item.origin_x) - WW'(in_item.center_x);
            w_reg[1] <= WW'(in_item.origin_y) - WW'(in_item.center_y);
            w_reg[2] <= WW'(in_item.origin_z) - WW'(in_item.center_z);
            d_reg[0] <= in_item.dir_x;
            d_reg[1] <= in_item.dir_y;
            d_reg[2] <= in_item.dir_z;
        end
    end

    // Stage 2: d_i * w_i and w_i * w_i
    logic signed [BPW-1:0] pb_reg [3];
    logic [SQW-1:0]        sq_reg [3];
    logic signed [LSW-1:0] sq_full [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_full[i] = LSW'(w_reg[i]) * LSW'(w_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                pb_reg[i] <= BPW'(d_reg[i]) * BPW'(w_reg[i]);
                sq_reg[i] <= sq_full[i][SQW-1:0];
            end
        end
    end

    // Stage 3: sums
    logic signed [BSW-1:0] bsum_reg;
    logic [LSW-1:0]        lsum_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            bsum_reg <= BSW'(pb_reg[0]) + BSW'(pb_reg[1]) + BSW'(pb_reg[2]);
            lsum_reg <= LSW'(sq_reg[0]) + LSW'(sq_reg[1]) + LSW'(sq_reg[2]);
        end
    end

    // Stage 4: round b half up to 16 fraction bits, subtract r^2
    logic signed [BSW-1:0]  bround;
    logic signed [B16W-1:0] b16_4_reg;
    logic signed [CCW-1:0]  cc_4_reg;

    assign bround = bsum_reg + BSW'(rsh_pkg::ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            b16_4_reg <= bround[BSW-1:FW];
            cc_4_reg  <= $signed({1'b0, lsum_reg}) - $signed(CCW'(rsq));
        end
    end

    // Stage 5: b^2
    logic signed [BB_W-1:0] bsq_full;
    logic [DW-1:0]          bsq_reg;
    logic signed [B16W-1:0] b16_5_reg;
    logic signed [CCW-1:0]  cc_5_reg;

    assign bsq_full = BB_W'(b16_4_reg) * BB_W'(b16_4_reg);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            bsq_reg   <= bsq_full[DW-1:0];
            b16_5_reg <= b16_4_reg;
            cc_5_reg  <= cc_4_reg;
        end
    end

    // Stage 6: delta = b^2 - cc, sign gives the hit flag
    logic signed [DW:0]     delta_full;
    logic [DW-1:0]          delta_reg;
    logic                   hit_reg;
    logic signed [B16W-1:0] b16_6_reg;

    assign delta_full = $signed({1'b0, bsq_reg}) - (DW+1)'(cc_5_reg);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            delta_reg <= delta_full[DW-1:0];
            hit_reg   <= !delta_full[DW];
            b16_6_reg <= b16_5_reg;
        end
    end

    assign in_ready       = en[0];
    assign out_valid      = v_reg[NSTG-1];
    assign out_item.hit   = hit_reg;
    assign out_item.b16   = b16_6_reg;
    assign out_item.delta = delta_reg;

    `RSH_ASSERT_IMPL(a_front_full_stall, aclk, aresetn, !in_ready,
        out_valid && !out_ready, "front end refused a transfer while a stage was free")

endmodule

// ===== rtl/core/rsh_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage (digit by digit).
// Carries the hit flag and rounded b alongside. Depends on rsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsh_sqrt_pipe (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsh_pkg::sqrt_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsh_pkg::root_item_t  out_item
);

    localparam int NSTG = rsh_pkg::ROOT_W;
    localparam int RTW  = rsh_pkg::ROOT_W;
    localparam int RMW  = rsh_pkg::REM_W;
    localparam int DW   = rsh_pkg::DELTA_W;
    localparam int B16W = rsh_pkg::B16_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;

    logic [RMW-1:0]         rem_reg  [NSTG];
    logic [RTW-1:0]         root_reg [NSTG];
    logic [DW-1:0]          rad_reg  [NSTG];
    logic                   hit_reg  [NSTG];
    logic signed [B16W-1:0] b16_reg  [NSTG];

    assign en[NSTG] = out_ready;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic [RMW-1:0]         rem_in;
        logic [RTW-1:0]         root_in;
        logic [DW-1:0]          rad_in;
        logic                   hit_in;
        logic signed [B16W-1:0] b16_in;
        logic                   valid_in;
        logic [RMW+1:0]         rem2;
        logic [RMW+1:0]         trial;
        logic [RMW+1:0]         diff;
        logic                   take;

        if (k == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = in_item.delta;
            assign hit_in   = in_item.hit;
            assign b16_in   = in_item.b16;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign hit_in   = hit_reg[k-1];
            assign b16_in   = b16_reg[k-1];
            assign valid_in = v_reg[k-1];
        end

        assign en[k] = !v_reg[k] || en[k+1];

        // Bring down the next digit pair and try (4*root + 1).
        assign rem2  = {rem_in, rad_in[DW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = rem2 >= trial;
        assign diff  = rem2 - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= take ? diff[RMW-1:0] : rem2[RMW-1:0];
                root_reg[k] <= {root_in[RTW-2:0], take};
                rad_reg[k]  <= {rad_in[DW-3:0], 2'b00};
                hit_reg[k]  <= hit_in;
                b16_reg[k]  <= b16_in;
            end
        end
    end

    assign in_ready      = en[0];
    assign out_valid     = v_reg[NSTG-1];
    assign out_item.hit  = hit_reg[NSTG-1];
    assign out_item.b16  = b16_reg[NSTG-1];
    assign out_item.root = root_reg[NSTG-1];

    // Remainder never exceeds twice the partial root.
    `RSH_ASSERT_IMPL(a_sqrt_rem_bound, aclk, aresetn, out_valid,
        rem_reg[NSTG-1] <= {root_reg[NSTG-1], 1'b0}, "square root remainder out of range")

endmodule

// ===== rtl/core/ray_sphere_hit_distance_core.sv =====
// Ray/sphere hit distance core: top level with output register.
// Depends on rsh_pkg, rsh_cfg, rsh_front, rsh_sqrt_pipe, assert_macros.svh.
//
// Usage:
//   s_* channel: one ray origin, unit direction and sphere centre per transfer.
//   m_* channel: one result per input transfer, in order: m_hit and the nearer
//   root m_distance (signed Q15.16, zero on a miss).
//   cfg_* channel: writes the sphere radius (unsigned Q7.16); cfg_ready is
//   always high. Write it only while no item is in flight.
// Pipeline: 6 front-end stages, 28 square-root stages and one output
//   register.
// Throughput: one item per cycle while m_ready is high; the 28-stage
//   digit-by-digit square root, one root bit per stage, sets the depth.
// Reset: aresetn (synchronous, active low) empties every stage and loads the
//   radius with 0.1.
// Stall: while m_ready is low the result holds; each stage takes new data
//   whenever it is empty or the stage after it advances, so bubbles close up
//   and s_ready drops only once every stage is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ray_sphere_hit_distance_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsh_pkg::RADIUS_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_origin_x,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_origin_y,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_origin_z,
    input  logic signed [rsh_pkg::DIR_W-1:0]    s_dir_x,
    input  logic signed [rsh_pkg::DIR_W-1:0]    s_dir_y,
    input  logic signed [rsh_pkg::DIR_W-1:0]    s_dir_z,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_center_x,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_center_y,
    input  logic signed [rsh_pkg::POS_W-1:0]    s_center_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic signed [rsh_pkg::DIST_W-1:0]   m_distance
);

    localparam int DSW = rsh_pkg::DIST_W;
    localparam int TW  = DSW + 1;
    localparam logic signed [DSW-1:0] DIST_MAX = {1'b0, {(DSW-1){1'b1}}};
    localparam logic signed [DSW-1:0] DIST_MIN = {1'b1, {(DSW-1){1'b0}}};

    logic [rsh_pkg::RSQ_W-1:0] rsq;
    rsh_pkg::ray_item_t        ray_item;
    rsh_pkg::sqrt_item_t       sq_item;
    rsh_pkg::root_item_t       rt_item;
    logic                      front_valid;
    logic                      front_ready;
    logic                      root_valid;
    logic                      root_ready;

    assign cfg_ready = 1'b1;

    rsh_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsq       (rsq)
    );

    assign ray_item.origin_x = s_origin_x;
    assign ray_item.origin_y = s_origin_y;
    assign ray_item.origin_z = s_origin_z;
    assign ray_item.dir_x    = s_dir_x;
    assign ray_item.dir_y    = s_dir_y;
    assign ray_item.dir_z    = s_dir_z;
    assign ray_item.center_x = s_center_x;
    assign ray_item.center_y = s_center_y;
    assign ray_item.center_z = s_center_z;

    rsh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (ray_item),
        .rsq       (rsq),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (sq_item)
    );

    rsh_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (sq_item),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_item  (rt_item)
    );

    // t = -b - sqrt(delta), clamped to the 32-bit range
    logic signed [TW-1:0]  t_full;
    logic signed [DSW-1:0] t_sat;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  hit_reg;
    logic signed [DSW-1:0] distance_reg;

    assign t_full = -TW'(rt_item.b16) - $signed(TW'(rt_item.root));

    always_comb begin
        if (t_full[TW-1] == t_full[TW-2]) begin
            t_sat = t_full[DSW-1:0];
        end else if (t_full[TW-1]) begin
            t_sat = DIST_MIN;
        end else begin
            t_sat = DIST_MAX;
        end
    end

    assign root_ready   = !m_valid_reg || m_ready;
    assign m_valid_next = root_ready ? root_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (root_ready) begin
            hit_reg      <= rt_item.hit;
            distance_reg <= rt_item.hit ? t_sat : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = hit_reg;
    assign m_distance = distance_reg;

    `RSH_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_hit,
        m_distance == '0, "miss carries a non-zero distance")
    `RSH_ASSERT_IMPL(a_input_stall, aclk, aresetn, !s_ready,
        m_valid && !m_ready, "input refused without an output stall")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for ray_sphere_hit_distance_core: ray items in, hit flag and distance out.
// Expected results come from a fixed-point predictor in this file.
// Depends on rsh_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int     ONE      = 1 << rsh_pkg::FRAC_W;
    localparam int     RW       = rsh_pkg::RADIUS_W;
    localparam longint DIST_MAX = (64'sd1 <<< (rsh_pkg::DIST_W - 1)) - 1;
    localparam longint DIST_MIN = -(64'sd1 <<< (rsh_pkg::DIST_W - 1));
    localparam int     POS_MAX  = (1 << (rsh_pkg::POS_W - 1)) - 1;
    localparam int     POS_MIN  = -(1 << (rsh_pkg::POS_W - 1));
    localparam int     DIR_MAX  = (1 << (rsh_pkg::DIR_W - 1)) - 1;
    localparam int     DIR_MIN  = -(1 << (rsh_pkg::DIR_W - 1));

    typedef struct {
        logic                              hit;
        logic signed [rsh_pkg::DIST_W-1:0] distance;
    } hit_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rsh_pkg::RADIUS_W-1:0]  cfg_data  = '0;

    logic                              s_valid    = 1'b0;
    logic                              s_ready;
    logic signed [rsh_pkg::POS_W-1:0]  s_origin_x = '0;
    logic signed [rsh_pkg::POS_W-1:0]  s_origin_y = '0;
    logic signed [rsh_pkg::POS_W-1:0]  s_origin_z = '0;
    logic signed [rsh_pkg::DIR_W-1:0]  s_dir_x    = '0;
    logic signed [rsh_pkg::DIR_W-1:0]  s_dir_y    = '0;
    logic signed [rsh_pkg::DIR_W-1:0]  s_dir_z    = '0;
    logic signed [rsh_pkg::POS_W-1:0]  s_center_x = '0;
    logic signed [rsh_pkg::POS_W-1:0]  s_center_y = '0;
    logic signed [rsh_pkg::POS_W-1:0]  s_center_z = '0;

    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_hit;
    logic signed [rsh_pkg::DIST_W-1:0] m_distance;

    hit_result_t                  expected_hits[$];
    hit_result_t                  due;
    logic [rsh_pkg::RADIUS_W-1:0] radius_now    = rsh_pkg::RADIUS_RESET;
    int                           mismatch_count = 0;
    int                           idle_pct       = 21;
    int                           stall_pct      = 21;
    int                           rx_hold_total  = 0;
    int                           rx_hold_count  = 0;

    ray_sphere_hit_distance_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_origin_x (s_origin_x),
        .s_origin_y (s_origin_y),
        .s_origin_z (s_origin_z),
        .s_dir_x    (s_dir_x),
        .s_dir_y    (s_dir_y),
        .s_dir_z    (s_dir_z),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_distance (m_distance)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Digit-by-digit integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned acc;
        longint unsigned probe;
        rem   = v;
        acc   = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= acc + probe) begin
                rem = rem - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    function automatic hit_result_t predict_hit_distance(
            input rsh_pkg::ray_item_t ray,
            input logic [rsh_pkg::RADIUS_W-1:0] radius);
        longint          o_v[3];
        longint          d_v[3];
        longint          c_v[3];
        longint          w_v;
        longint          dot_full;
        longint          len_sq;
        longint          b_round;
        longint          c_term;
        longint          disc;
        longint          r_val;
        longint          t_val;
        hit_result_t     res;
        o_v[0] = ray.origin_x;  o_v[1] = ray.origin_y;  o_v[2] = ray.origin_z;
        d_v[0] = ray.dir_x;     d_v[1] = ray.dir_y;     d_v[2] = ray.dir_z;
        c_v[0] = ray.center_x;  c_v[1] = ray.center_y;  c_v[2] = ray.center_z;
        dot_full = 0;
        len_sq   = 0;
        for (int i = 0; i < 3; i++) begin
            w_v      = o_v[i] - c_v[i];
            dot_full = dot_full + d_v[i] * w_v;
            len_sq   = len_sq + w_v * w_v;
        end
        // round half up to 16 fraction bits; arithmetic shift floors
        b_round = (dot_full + rsh_pkg::ROUND_HALF) >>> rsh_pkg::FRAC_W;
        r_val   = longint'(radius);
        c_term  = len_sq - r_val * r_val;
        disc    = b_round * b_round - c_term;
        if (disc < 0) begin
            res.hit      = 1'b0;
            res.distance = '0;
        end else begin
            t_val = -b_round - longint'(floor_sqrt(disc));
            if (t_val > DIST_MAX)
                t_val = DIST_MAX;
            if (t_val < DIST_MIN)
                t_val = DIST_MIN;
            res.hit      = 1'b1;
            res.distance = t_val[rsh_pkg::DIST_W-1:0];
        end
        return res;
    endfunction

    function automatic rsh_pkg::ray_item_t make_ray(input int ox, input int oy, input int oz,
                                                    input int dx, input int dy, input int dz,
                                                    input int cx, input int cy, input int cz);
        rsh_pkg::ray_item_t r;
        r.origin_x = ox[rsh_pkg::POS_W-1:0];
        r.origin_y = oy[rsh_pkg::POS_W-1:0];
        r.origin_z = oz[rsh_pkg::POS_W-1:0];
        r.dir_x    = dx[rsh_pkg::DIR_W-1:0];
        r.dir_y    = dy[rsh_pkg::DIR_W-1:0];
        r.dir_z    = dz[rsh_pkg::DIR_W-1:0];
        r.center_x = cx[rsh_pkg::POS_W-1:0];
        r.center_y = cy[rsh_pkg::POS_W-1:0];
        r.center_z = cz[rsh_pkg::POS_W-1:0];
        return r;
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic rsh_pkg::ray_item_t raw_ray();
        return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    endfunction

    // Unit direction from the origin towards a point jittered around the centre, negated when reverse is set.
    function automatic rsh_pkg::ray_item_t aim_ray(input int spread, input int jitter,
                                                   input bit reverse);
        int  c[3];
        int  o[3];
        int  d[3];
        real v[3];
        real len;
        for (int i = 0; i < 3; i++) begin
            c[i] = rand_span(4000000);
            o[i] = c[i] + rand_span(spread);
            v[i] = real'(c[i] + rand_span(jitter) - o[i]);
        end
        len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (len == 0.0) begin
            v[0] = 1.0;
            len  = 1.0;
        end
        for (int i = 0; i < 3; i++) begin
            d[i] = $rtoi(v[i] / len * real'(ONE));
            if (reverse)
                d[i] = -d[i];
        end
        return make_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2]);
    endfunction

    function automatic rsh_pkg::ray_item_t mixed_ray();
        int pick;
        int spread;
        int jitter;
        pick   = $urandom_range(99);
        jitter = 2 * int'(radius_now) + 1;
        case ($urandom_range(3))
            0:       spread = 4 * int'(radius_now) + 16;
            1:       spread = 4 * ONE;
            2:       spread = 1 << 20;
            default: spread = 1 << 22;
        endcase
        if (pick < 60)
            return aim_ray(spread, jitter, $urandom_range(9) == 0);
        else if (pick < 75)
            return aim_ray(spread, 8 * jitter, 1'b0);
        return raw_ray();
    endfunction

    // Record the prediction for every input transfer.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_hits.insert(expected_hits.size(), predict_hit_distance(
                {s_origin_x, s_origin_y, s_origin_z, s_dir_x, s_dir_y, s_dir_z,
                 s_center_x, s_center_y, s_center_z}, radius_now));
    end

    // Receiver: hold off for requested stretches, otherwise stall at random.
    always @(posedge aclk) begin
        if (rx_hold_count < rx_hold_total) begin
            m_ready       <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result: hit %0b distance %0d", m_hit, m_distance);
                mismatch_count++;
            end else begin
                due = expected_hits.pop_front();
                if (m_hit !== due.hit) begin
                    $error("hit: expected %0b, got %0b", due.hit, m_hit);
                    mismatch_count++;
                end
                if (m_distance !== due.distance) begin
                    $error("distance: expected %0d, got %0d", due.distance, m_distance);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_ray(input rsh_pkg::ray_item_t ray);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_origin_x <= ray.origin_x;
        s_origin_y <= ray.origin_y;
        s_origin_z <= ray.origin_z;
        s_dir_x    <= ray.dir_x;
        s_dir_y    <= ray.dir_y;
        s_dir_z    <= ray.dir_z;
        s_center_x <= ray.center_x;
        s_center_y <= ray.center_y;
        s_center_z <= ray.center_z;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        // let the prediction for the last transfer land before testing the queue
        @(posedge aclk);
        while (expected_hits.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_radius(input logic [rsh_pkg::RADIUS_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid  <= 1'b0;
        radius_now  = value;
    endtask

    task automatic send_mixed(input int count);
        for (int i = 0; i < count; i++)
            send_ray(mixed_ray());
    endtask

    // Reset radius of 0.1: plain hit, sphere behind, miss, tangent, origin inside,
    // degenerate and out-of-range directions, extreme positions.
    task automatic test_directed_rays();
        send_ray(make_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, -ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_ray(make_ray(0, int'(rsh_pkg::RADIUS_RESET), 0, ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 0));
        send_ray(make_ray(ONE, ONE, 0, 0, 0, 0, ONE, ONE, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, 0, ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, ONE / 2, 0, 0, ONE, 0, 0));
        send_ray(make_ray(0, 0, 0, DIR_MAX, DIR_MIN, ONE + 1, ONE, 0, 0));
        send_ray(make_ray(POS_MAX, POS_MAX, POS_MAX, ONE, 0, 0, POS_MIN, POS_MIN, POS_MIN));
        send_ray(make_ray(POS_MIN, POS_MIN, POS_MIN, -ONE, -ONE, -ONE,
                          POS_MAX, POS_MAX, POS_MAX));
        send_ray(make_ray(POS_MAX, POS_MIN, POS_MAX, DIR_MIN, DIR_MIN, DIR_MIN,
                          POS_MIN, POS_MAX, POS_MIN));
        send_ray(make_ray(POS_MAX, POS_MAX, POS_MAX, DIR_MAX, DIR_MAX, DIR_MAX,
                          POS_MAX, POS_MAX, POS_MAX));
        send_ray(make_ray(POS_MIN, POS_MIN, POS_MIN, 0, DIR_MIN, 0, POS_MIN, POS_MIN, POS_MIN));
        send_ray(make_ray(POS_MIN, 0, POS_MAX, ONE, -ONE, ONE, POS_MAX, -1, POS_MIN));
        wait_drained();
    endtask

    task automatic test_radius_settings();
        logic [rsh_pkg::RADIUS_W-1:0] settings[4];
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = RW'($urandom_range(8 * ONE));
        settings[3] = rsh_pkg::RADIUS_RESET;
        foreach (settings[k]) begin
            write_radius(settings[k]);
            send_ray(make_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0));
            send_ray(make_ray(POS_MAX, POS_MIN, 0, DIR_MIN, DIR_MAX, 0, POS_MIN, POS_MAX, 0));
            send_mixed(150);
            wait_drained();
        end
    endtask

    task automatic test_sender_pause();
        send_mixed(60);
        wait_drained();
        send_mixed(60);
        wait_drained();
    endtask

    // Hold the result channel while the sender keeps offering, so the pipe fills.
    task automatic test_output_holdoff();
        idle_pct      = 0;
        rx_hold_total = rx_hold_total + 300;
        send_mixed(150);
        idle_pct = 21;
        wait_drained();
    endtask

    task automatic test_unbroken_stream();
        idle_pct  = 0;
        stall_pct = 0;
        send_mixed(200);
        wait_drained();
        idle_pct  = 21;
        stall_pct = 21;
    endtask

    task automatic test_random_rays();
        write_radius(RW'($urandom_range(2 * ONE)));
        send_mixed(400);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_rays();
        test_radius_settings();
        test_sender_pause();
        test_output_holdoff();
        test_unbroken_stream();
        test_random_rays();
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== ray_sphere_hit_distance_core.f =====
+incdir+rtl/core
rtl/core/rsh_pkg.sv
rtl/core/rsh_cfg.sv
rtl/core/rsh_front.sv
rtl/core/rsh_sqrt_pipe.sv
rtl/core/ray_sphere_hit_distance_core.sv
tb/sv/tb.sv
